// File: hw/rtl/hdq_pkg.sv
package hdq_pkg;

    localparam int DEPTH = 16;
    localparam int HANDLE_W = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;
    localparam int OUT_HANDLE_W = 8;

    typedef enum logic [2:0] {
        OP_PUSH_BACK   = 3'd0,
        OP_PUSH_FRONT  = 3'd1,
        OP_POP_FRONT   = 3'd2,
        OP_POP_BACK    = 3'd3,
        OP_READ_AT     = 3'd4,
        OP_DELETE_AT   = 3'd5,
        OP_REMOVE      = 3'd6,
        OP_CLEAR       = 3'd7
    } t_op;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl;

endpackage

// File: hw/rtl/hdq_ctrl.sv
module hdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output hdq_pkg::t_ctrl o_ctrl
);

    hdq_pkg::t_state r_state;
    hdq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            s_ready;

    assign s_ready = (r_state == hdq_pkg::S_IDLE) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hdq_pkg::S_IDLE: begin
                if (i_s_tvalid && s_ready) begin
                    n_state = hdq_pkg::S_EXEC;
                end
            end
            hdq_pkg::S_EXEC: begin
                n_state = hdq_pkg::S_IDLE;
            end
            default: begin
                n_state = hdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl.capture = 1'b0;
        o_ctrl.execute = 1'b0;
        unique case (r_state)
            hdq_pkg::S_IDLE: begin
                o_ctrl.capture = i_s_tvalid && s_ready;
            end
            hdq_pkg::S_EXEC: begin
                o_ctrl.execute = 1'b1;
            end
            default: begin
                o_ctrl.execute = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (o_ctrl.execute) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;

endmodule

// File: hw/rtl/hdq_datapath.sv
module hdq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hdq_pkg::t_ctrl                    i_ctrl,
    input  logic [2:0]                        i_cmd,
    input  logic [7:0]                        i_handle_in,
    input  logic [hdq_pkg::POS_W-1:0]         i_position,
    output logic [1:0]                        o_status,
    output logic [hdq_pkg::OUT_HANDLE_W-1:0]  o_handle_out,
    output logic                              o_handle_valid,
    output logic [hdq_pkg::CNT_W-1:0]         o_entries
);

    hdq_pkg::t_op                       r_op;
    logic [hdq_pkg::HANDLE_W-1:0]       r_h;
    logic [hdq_pkg::POS_W-1:0]          r_pos;
    logic [hdq_pkg::CNT_W-1:0]          r_occ;
    logic [hdq_pkg::CNT_W-1:0]          n_occ;
    logic [hdq_pkg::HANDLE_W-1:0]       r_store [hdq_pkg::DEPTH];
    logic [hdq_pkg::HANDLE_W-1:0]       n_store [hdq_pkg::DEPTH];

    logic [1:0]                         r_status;
    logic [hdq_pkg::OUT_HANDLE_W-1:0]   r_hout;
    logic                               r_hvalid;
    logic [hdq_pkg::CNT_W-1:0]          r_entries;
    logic [1:0]                         n_status;
    logic [hdq_pkg::OUT_HANDLE_W-1:0]   n_hout;
    logic                               n_hvalid;

    logic                               full;
    logic                               empty;
    logic                               pos_ok;
    logic [hdq_pkg::DEPTH-1:0]          match;
    logic                               found;
    logic [hdq_pkg::IDX_W-1:0]          match_idx;
    logic [hdq_pkg::IDX_W-1:0]          back_idx;
    logic [hdq_pkg::IDX_W-1:0]          rd_idx;
    logic [hdq_pkg::HANDLE_W-1:0]       rd_data;
    logic                               do_push_back;
    logic                               do_push_front;
    logic                               do_take;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_op  <= hdq_pkg::t_op'(i_cmd);
            r_h   <= i_handle_in[hdq_pkg::HANDLE_W-1:0];
            r_pos <= i_position;
        end
    end

    assign full     = (r_occ == hdq_pkg::CNT_W'(hdq_pkg::DEPTH));
    assign empty    = (r_occ == '0);
    assign pos_ok   = (hdq_pkg::CNT_W'(r_pos) < r_occ);
    assign back_idx = hdq_pkg::IDX_W'(r_occ - hdq_pkg::CNT_W'(1));

    always_comb begin
        for (int i = 0; i < hdq_pkg::DEPTH; i++) begin
            match[i] = (hdq_pkg::CNT_W'(i) < r_occ) && (r_store[i] == r_h);
        end
        found     = 1'b0;
        match_idx = '0;
        for (int i = hdq_pkg::DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                found     = 1'b1;
                match_idx = hdq_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        do_push_back  = 1'b0;
        do_push_front = 1'b0;
        do_take       = 1'b0;
        rd_idx        = '0;
        n_status      = hdq_pkg::STAT_OK;
        n_hvalid      = 1'b0;
        n_occ         = r_occ;
        unique case (r_op)
            hdq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = hdq_pkg::STAT_FULL;
                end else begin
                    do_push_back = 1'b1;
                end
            end
            hdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = hdq_pkg::STAT_FULL;
                end else begin
                    do_push_front = 1'b1;
                end
            end
            hdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = hdq_pkg::STAT_MISS;
                end else begin
                    do_take = 1'b1;
                end
            end
            hdq_pkg::OP_POP_BACK: begin
                rd_idx = back_idx;
                if (empty) begin
                    n_status = hdq_pkg::STAT_MISS;
                end else begin
                    do_take = 1'b1;
                end
            end
            hdq_pkg::OP_READ_AT: begin
                rd_idx = r_pos[hdq_pkg::IDX_W-1:0];
                if (!pos_ok) begin
                    n_status = hdq_pkg::STAT_MISS;
                end else begin
                    n_hvalid = 1'b1;
                end
            end
            hdq_pkg::OP_DELETE_AT: begin
                rd_idx = r_pos[hdq_pkg::IDX_W-1:0];
                if (!pos_ok) begin
                    n_status = hdq_pkg::STAT_MISS;
                end else begin
                    do_take = 1'b1;
                end
            end
            hdq_pkg::OP_REMOVE: begin
                rd_idx = match_idx;
                if (!found) begin
                    n_status = hdq_pkg::STAT_MISS;
                end else begin
                    do_take = 1'b1;
                end
            end
            hdq_pkg::OP_CLEAR: begin
                n_occ = '0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
        if (do_take) begin
            n_hvalid = 1'b1;
            n_occ    = r_occ - hdq_pkg::CNT_W'(1);
        end
        if (do_push_back || do_push_front) begin
            n_occ = r_occ + hdq_pkg::CNT_W'(1);
        end
    end

    assign rd_data = r_store[rd_idx];

    always_comb begin
        n_hout = '0;
        if (n_hvalid) begin
            n_hout = hdq_pkg::OUT_HANDLE_W'(rd_data);
        end else if (r_op == hdq_pkg::OP_CLEAR) begin
            n_hout = hdq_pkg::OUT_HANDLE_W'(r_occ);
        end
    end

    always_comb begin
        for (int i = 0; i < hdq_pkg::DEPTH; i++) begin
            n_store[i] = r_store[i];
        end
        if (do_push_back) begin
            n_store[r_occ[hdq_pkg::IDX_W-1:0]] = r_h;
        end
        if (do_push_front) begin
            n_store[0] = r_h;
            for (int i = 1; i < hdq_pkg::DEPTH; i++) begin
                n_store[i] = r_store[i-1];
            end
        end
        if (do_take) begin
            for (int i = 0; i < hdq_pkg::DEPTH - 1; i++) begin
                if (hdq_pkg::IDX_W'(i) >= rd_idx) begin
                    n_store[i] = r_store[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.execute) begin
            for (int i = 0; i < hdq_pkg::DEPTH; i++) begin
                r_store[i] <= n_store[i];
            end
            r_status  <= n_status;
            r_hout    <= n_hout;
            r_hvalid  <= n_hvalid;
            r_entries <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_ctrl.execute) begin
            r_occ <= n_occ;
        end
    end

    assign o_status       = r_status;
    assign o_handle_out   = r_hout;
    assign o_handle_valid = r_hvalid;
    assign o_entries      = r_entries;

endmodule

// File: hw/rtl/handle_deque_with_indexed_delete_top.sv
// Ordered queue of up to 16 buffer handles with push and pop at both ends, read and
// delete at an index, remove by value, and clear; each request gives one result with
// a status, the handle taken out or read (on clear, the count cleared), and the count
// left queued. A request is first registered; then, in the execute state, the cell row
// shifts and compares all entries at once and the result register loads. A new
// request is accepted only in the idle state, when no result is waiting or the waiting
// result leaves on the same edge; no new request is taken while one is in progress.
module handle_deque_with_indexed_delete_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // handle_in[7:0], position[11:8], zero[15:12]
    input  logic [2:0]  i_s_tuser,  // cmd[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // handle_out[7:0], entries[12:8], zero[15:13]
    output logic [2:0]  o_m_tuser   // status[1:0], handle_valid[2]
);

    hdq_pkg::t_ctrl                     ctrl;
    logic [1:0]                         status;
    logic [hdq_pkg::OUT_HANDLE_W-1:0]   handle_out;
    logic                               handle_valid;
    logic [hdq_pkg::CNT_W-1:0]          entries;

    hdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctrl     (ctrl)
    );

    hdq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cmd          (i_s_tuser),
        .i_handle_in    (i_s_tdata[7:0]),
        .i_position     (i_s_tdata[11:8]),
        .o_status       (status),
        .o_handle_out   (handle_out),
        .o_handle_valid (handle_valid),
        .o_entries      (entries)
    );

    assign o_m_tdata = {3'b000, entries, handle_out};
    assign o_m_tuser = {handle_valid, status};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("Request accepted while another is in progress.");

    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (entries <= hdq_pkg::CNT_W'(hdq_pkg::DEPTH)))
        else $error("Entry count exceeds the queue depth.");

    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && handle_valid) |-> (status == hdq_pkg::STAT_OK))
        else $error("Handle reported with a failing status.");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.execute |=> o_m_tvalid)
        else $error("Executed request produced no result.");

endmodule
